[design/closest_joint_solution_select_assert.svh]
// closest_joint_solution_select_assert.svh: assertion macros for the selector
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef CLOSEST_JOINT_SOLUTION_SELECT_ASSERT_SVH
`define CLOSEST_JOINT_SOLUTION_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CJSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CJSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cjss_pkg.sv]
// cjss_pkg: constants, types and helper functions of the joint solution selector
// used by every module and interface; depends on nothing
`default_nettype none

package cjss_pkg;

  localparam int JOINTS      = 6;
  localparam int ANGLE_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int LIMIT_W     = 15;
  localparam int WEIGHT_W    = 10;
  localparam int COST_W      = 37;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 1;

  // arithmetic widths
  localparam int DIFF_W  = ANGLE_WIDTH + 1;
  localparam int MAG_W   = (DIFF_W > 20) ? 20 : DIFF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int PEN_W   = WEIGHT_W + 2 * FRAC_BITS;
  localparam int TERM_W  = ((SQ_W > PEN_W) ? SQ_W : PEN_W) + 1;
  localparam int SUM_W   = TERM_W + 3;
  localparam int CMP_W   = ((ANGLE_WIDTH > LIMIT_W) ? ANGLE_WIDTH : LIMIT_W) + 1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(12868);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(100);
  localparam logic [COST_W-1:0]   COST_ONES    = '1;
  localparam logic [COST_W-1:0]   COST_TOP     = {{(COST_W-1){1'b1}}, 1'b0};
  localparam logic [63:0]         DIFF_CLAMP   = 64'h0000_0000_0008_0000;

  typedef enum logic [0:0] {
    OP_LOAD_REF = 1'b0,
    OP_ROW      = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_LIMIT    = 1'b0,
    REG_PENALTY_WEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef angle_t [JOINTS-1:0]           angle_vec_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef sq_t [JOINTS-1:0]              sq_vec_t;
  typedef logic [COST_W-1:0]             cost_t;

  typedef struct packed {
    op_e                          operation;
    logic signed [ANGLE_WIDTH-1:0] angle_0;
    logic signed [ANGLE_WIDTH-1:0] angle_1;
    logic signed [ANGLE_WIDTH-1:0] angle_2;
    logic signed [ANGLE_WIDTH-1:0] angle_3;
    logic signed [ANGLE_WIDTH-1:0] angle_4;
    logic signed [ANGLE_WIDTH-1:0] angle_5;
    logic                         row_valid;
    logic                         last_row;
  } in_item_t;

  typedef struct packed {
    logic                         found;
    logic signed [ANGLE_WIDTH-1:0] best_0;
    logic signed [ANGLE_WIDTH-1:0] best_1;
    logic signed [ANGLE_WIDTH-1:0] best_2;
    logic signed [ANGLE_WIDTH-1:0] best_3;
    logic signed [ANGLE_WIDTH-1:0] best_4;
    logic signed [ANGLE_WIDTH-1:0] best_5;
    logic [COST_W-1:0]            best_cost;
  } out_item_t;

  // control flags that follow a row down the pipeline
  typedef struct packed {
    logic vld;
    logic row_valid;
    logic last;
  } stage_ctrl_t;

  function automatic angle_vec_t pack_angles(input in_item_t it);
    angle_vec_t v;
    v[0] = it.angle_0;
    v[1] = it.angle_1;
    v[2] = it.angle_2;
    v[3] = it.angle_3;
    v[4] = it.angle_4;
    v[5] = it.angle_5;
    return v;
  endfunction

  function automatic out_item_t make_result(input logic found, input angle_vec_t best,
                                            input cost_t cost);
    out_item_t r;
    r.found     = found;
    r.best_0    = best[0];
    r.best_1    = best[1];
    r.best_2    = best[2];
    r.best_3    = best[3];
    r.best_4    = best[4];
    r.best_5    = best[5];
    r.best_cost = cost;
    return r;
  endfunction

  // larger differences only matter through saturation, so cap the magnitude
  function automatic mag_t clamp_mag(input logic [DIFF_W-1:0] m);
    logic [63:0] w;
    w = 64'(m);
    if (w > DIFF_CLAMP) begin
      w = DIFF_CLAMP;
    end
    return w[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/cjss_if.sv]
// cjss_in_if / cjss_out_if: valid-ready channels of the joint solution selector
// depends on cjss_pkg for the payload types
`default_nettype none

interface cjss_in_if;
  logic                valid;
  logic                ready;
  cjss_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cjss_out_if;
  logic                valid;
  logic                ready;
  cjss_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/closest_joint_solution_select.sv]
// closest_joint_solution_select: picks the candidate joint row nearest a reference
// uses cjss_pkg, cjss_if, cjss_lane, cjss_merge, cjss_select and the assert macros
//
// Usage:
//   in_i carries items: operation OP_LOAD_REF stores six reference angles and
//   gives no result; operation OP_ROW scores one candidate row. A row with
//   last_row set closes the group and, after it passes the lane and merge stages
//   into the result register, out_o shows one result (found flag, best angles,
//   best cost). One item is taken every cycle while in_i.ready is high; six lanes
//   square the joint differences in parallel, one merge stage adds them, and only
//   the running-minimum compare in the select stage carries from row to row.
//   When out_o is stalled the pipeline keeps taking rows while it has empty
//   stages; a closing row waits in the merge stage until the result register
//   is free, and in_i.ready drops once every stage holds a row.
//   Reset sets angle_limit to pi in Q4.12 and penalty_weight to 100, clears the
//   reference to zero and empties the group (cost all ones, found low).
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
`default_nettype none

`include "closest_joint_solution_select_assert.svh"

module closest_joint_solution_select (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cjss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cjss_pkg::CFG_W-1:0]       cfg_data_i,
  cjss_in_if.sink                               in_i,
  cjss_out_if.source                            out_o
);

  logic [cjss_pkg::LIMIT_W-1:0]  limit_q;
  logic [cjss_pkg::WEIGHT_W-1:0] weight_q;
  cjss_pkg::angle_vec_t          ref_q, in_angles;
  logic                          accept;

  cjss_pkg::stage_ctrl_t s1_ctrl_d, s1_ctrl_q, s2_ctrl_d, s2_ctrl_q;
  cjss_pkg::angle_vec_t  s1_angles_q, s2_angles_q;
  logic                  s1_free, s2_free, s2_take;

  cjss_pkg::sq_vec_t             lane_sq;
  logic [cjss_pkg::JOINTS-1:0]   lane_pen;
  cjss_pkg::cost_t               s2_cost;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= cjss_pkg::LIMIT_RESET;
      weight_q <= cjss_pkg::WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cjss_pkg::cfg_reg_e'(cfg_idx_i))
        cjss_pkg::REG_ANGLE_LIMIT:    limit_q  <= cfg_data_i[cjss_pkg::LIMIT_W-1:0];
        cjss_pkg::REG_PENALTY_WEIGHT: weight_q <= cfg_data_i[cjss_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_angles = cjss_pkg::pack_angles(in_i.data);
  assign accept    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (accept && (in_i.data.operation == cjss_pkg::OP_LOAD_REF)) begin
      ref_q <= in_angles;
    end
  end

  // pipeline flow: a stage loads when empty or when its row moves on
  always_comb begin
    s2_free = !s2_ctrl_q.vld || s2_take;
    s1_free = !s1_ctrl_q.vld || s2_free;

    s1_ctrl_d = s1_ctrl_q;
    if (s1_free) begin
      s1_ctrl_d.vld       = accept && (in_i.data.operation == cjss_pkg::OP_ROW);
      s1_ctrl_d.row_valid = in_i.data.row_valid;
      s1_ctrl_d.last      = in_i.data.last_row;
    end

    s2_ctrl_d = s2_free ? s1_ctrl_q : s2_ctrl_q;
  end

  assign in_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
      s2_ctrl_q <= '0;
    end else begin
      s1_ctrl_q <= s1_ctrl_d;
      s2_ctrl_q <= s2_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_angles_q <= in_angles;
    end
    if (s2_free) begin
      s2_angles_q <= s1_angles_q;
    end
  end

  for (genvar j = 0; j < cjss_pkg::JOINTS; j++) begin : g_lane
    cjss_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (s1_free),
      .angle_i (in_angles[j]),
      .ref_i   (ref_q[j]),
      .limit_i (limit_q),
      .sq_o    (lane_sq[j]),
      .pen_o   (lane_pen[j])
    );
  end

  cjss_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (s2_free),
    .sq_i     (lane_sq),
    .pen_i    (lane_pen),
    .weight_i (weight_q),
    .cost_o   (s2_cost)
  );

  cjss_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (s2_ctrl_q),
    .cost_i      (s2_cost),
    .angles_i    (s2_angles_q),
    .out_ready_i (out_o.ready),
    .take_o      (s2_take),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  `CJSS_ASSERT_IMP(a_none_cost, out_o.valid && !out_o.data.found,
                   out_o.data.best_cost == cjss_pkg::COST_ONES,
                   "empty group result without all-ones cost")
  `CJSS_ASSERT_IMP(a_found_cost, out_o.valid && out_o.data.found,
                   out_o.data.best_cost != cjss_pkg::COST_ONES,
                   "found result carries reserved cost")
  `CJSS_ASSERT_NXT(a_emit, s2_ctrl_q.vld && s2_ctrl_q.last && s2_take, out_o.valid,
                   "closing row gave no result")
  `CJSS_ASSERT_IMP(a_empty_ready, !s1_ctrl_q.vld, in_i.ready,
                   "empty first stage refuses an item")

endmodule

`default_nettype wire

[design/cjss_lane.sv]
// cjss_lane: one joint of a row, squared distance to the reference and range check
// depends on cjss_pkg
`default_nettype none

module cjss_lane (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire cjss_pkg::angle_t                angle_i,
  input  wire cjss_pkg::angle_t                ref_i,
  input  wire logic [cjss_pkg::LIMIT_W-1:0]    limit_i,
  output cjss_pkg::sq_t                        sq_o,
  output logic                                 pen_o
);

  logic signed [cjss_pkg::DIFF_W-1:0] diff;
  logic [cjss_pkg::DIFF_W-1:0]        mag;
  cjss_pkg::mag_t                     mag_c;
  cjss_pkg::sq_t                      sq_d, sq_q;
  logic signed [cjss_pkg::CMP_W-1:0]  a_ext, lim_ext;
  logic                               pen_d, pen_q;

  always_comb begin
    diff  = cjss_pkg::DIFF_W'(angle_i) - cjss_pkg::DIFF_W'(ref_i);
    mag   = diff[cjss_pkg::DIFF_W-1] ? cjss_pkg::DIFF_W'(-diff) : cjss_pkg::DIFF_W'(diff);
    mag_c = cjss_pkg::clamp_mag(mag);
    sq_d  = cjss_pkg::SQ_W'(mag_c) * cjss_pkg::SQ_W'(mag_c);

    a_ext   = cjss_pkg::CMP_W'(angle_i);
    lim_ext = $signed(cjss_pkg::CMP_W'(limit_i));
    pen_d   = (a_ext > lim_ext) || (a_ext < -lim_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      pen_q <= pen_d;
    end
  end

  assign sq_o  = sq_q;
  assign pen_o = pen_q;

endmodule

`default_nettype wire

[design/cjss_merge.sv]
// cjss_merge: adds the lane squares and penalties of a row into its clamped cost
// depends on cjss_pkg
`default_nettype none

module cjss_merge (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire cjss_pkg::sq_vec_t               sq_i,
  input  wire logic [cjss_pkg::JOINTS-1:0]     pen_i,
  input  wire logic [cjss_pkg::WEIGHT_W-1:0]   weight_i,
  output cjss_pkg::cost_t                      cost_o
);

  logic [cjss_pkg::TERM_W-1:0] pen_val;
  logic [cjss_pkg::TERM_W-1:0] term [cjss_pkg::JOINTS];
  logic [cjss_pkg::SUM_W-1:0]  sum;
  cjss_pkg::cost_t             cost_d, cost_q;

  always_comb begin
    // penalty is whole units, so shift into the 24 fraction bits of the cost
    pen_val = cjss_pkg::TERM_W'(weight_i) << (2 * cjss_pkg::FRAC_BITS);
    sum     = '0;
    for (int j = 0; j < cjss_pkg::JOINTS; j++) begin
      term[j] = cjss_pkg::TERM_W'(sq_i[j]) + (pen_i[j] ? pen_val : '0);
      sum     = sum + cjss_pkg::SUM_W'(term[j]);
    end
    // all-ones stays reserved for an empty group
    if (sum > cjss_pkg::SUM_W'(cjss_pkg::COST_TOP)) begin
      cost_d = cjss_pkg::COST_TOP;
    end else begin
      cost_d = sum[cjss_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cost_q <= cost_d;
    end
  end

  assign cost_o = cost_q;

endmodule

`default_nettype wire

[design/cjss_select.sv]
// cjss_select: running minimum over a group of rows and the result register
// depends on cjss_pkg
`default_nettype none

module cjss_select (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cjss_pkg::stage_ctrl_t ctrl_i,
  input  wire cjss_pkg::cost_t       cost_i,
  input  wire cjss_pkg::angle_vec_t  angles_i,
  input  wire logic                  out_ready_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  output cjss_pkg::out_item_t        out_data_o
);

  cjss_pkg::cost_t     min_d, min_q, min_n;
  cjss_pkg::angle_vec_t best_d, best_q, best_n;
  logic                seen_d, seen_q, seen_n;
  logic                better, fire, close;
  logic                out_valid_d, out_valid_q;
  cjss_pkg::out_item_t out_data_q;

  always_comb begin
    // a closing row needs room in the result register
    take_o = !ctrl_i.last || !out_valid_q || out_ready_i;
    fire   = ctrl_i.vld && take_o;
    close  = fire && ctrl_i.last;

    // strict compare keeps the first row on a tie
    better = ctrl_i.row_valid && (cost_i < min_q);
    min_n  = better ? cost_i : min_q;
    best_n = better ? angles_i : best_q;
    seen_n = seen_q | ctrl_i.row_valid;

    min_d  = min_q;
    best_d = best_q;
    seen_d = seen_q;
    if (close) begin
      min_d  = cjss_pkg::COST_ONES;
      best_d = '0;
      seen_d = 1'b0;
    end else if (fire) begin
      min_d  = min_n;
      best_d = best_n;
      seen_d = seen_n;
    end

    if (close) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= cjss_pkg::COST_ONES;
      best_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      min_q       <= min_d;
      best_q      <= best_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      out_data_q <= cjss_pkg::make_result(seen_n, best_n, min_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[sim/closest_joint_solution_select_test.sv]
// closest_joint_solution_select_test: self-checking bench for the nearest joint row selector
// depends on cjss_pkg, cjss_in_if / cjss_out_if and closest_joint_solution_select
// a directed table, then random groups of rows under several limit / weight settings
`timescale 1ns / 1ps

module closest_joint_solution_select_test;
  import cjss_pkg::*;

  localparam longint unsigned COST_SAT = 64'(COST_ONES);
  localparam longint unsigned COST_MAX = 64'(COST_TOP);

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  cjss_in_if  in_ch ();
  cjss_out_if out_ch ();

  closest_joint_solution_select uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  angle_t           ref_pose [JOINTS];
  angle_t           best_pose [JOINTS];
  longint unsigned  best_run;
  bit               seen_valid;
  logic [LIMIT_W-1:0]  lim_reg;
  logic [WEIGHT_W-1:0] wt_reg;

  out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        mismatch_count = 0;
  bit        no_gaps = 1'b0;

  function automatic void queue_result(input out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic angle_vec_t row_angles(input in_item_t it);
    angle_vec_t v;
    v[0] = it.angle_0;
    v[1] = it.angle_1;
    v[2] = it.angle_2;
    v[3] = it.angle_3;
    v[4] = it.angle_4;
    v[5] = it.angle_5;
    return v;
  endfunction

  function automatic in_item_t make_item(input op_e op, input angle_vec_t v, input bit vld,
                                         input bit last);
    in_item_t it;
    it.operation = op;
    it.angle_0   = v[0];
    it.angle_1   = v[1];
    it.angle_2   = v[2];
    it.angle_3   = v[3];
    it.angle_4   = v[4];
    it.angle_5   = v[5];
    it.row_valid = vld;
    it.last_row  = last;
    return it;
  endfunction

  function automatic void open_group();
    int j;
    best_run   = COST_SAT;
    seen_valid = 1'b0;
    for (j = 0; j < JOINTS; j++) begin
      best_pose[j] = '0;
    end
  endfunction

  // scores one item against the reference, or loads the reference; returns 1 when it closes a group
  function automatic bit score_row(input in_item_t it, output out_item_t res);
    angle_vec_t      v;
    longint unsigned acc;
    longint unsigned m;
    longint          a;
    longint          d;
    longint          lim;
    int              j;
    res = '0;
    v = row_angles(it);
    if (it.operation == OP_LOAD_REF) begin
      for (j = 0; j < JOINTS; j++) begin
        ref_pose[j] = v[j];
      end
      return 1'b0;
    end
    if (it.row_valid) begin
      acc = 0;
      lim = longint'(lim_reg);
      for (j = 0; j < JOINTS; j++) begin
        a = longint'(v[j]);
        d = a - longint'(ref_pose[j]);
        m = (d < 0) ? longint'(-d) : longint'(d);
        if (m > DIFF_CLAMP) begin
          m = DIFF_CLAMP;
        end
        acc = acc + m * m;
        if (acc > COST_SAT) begin
          acc = COST_SAT;
        end
        if (a < -lim || a > lim) begin
          acc = acc + (longint'(wt_reg) << (2 * FRAC_BITS));
          if (acc > COST_SAT) begin
            acc = COST_SAT;
          end
        end
      end
      // all ones is kept for an empty group
      if (acc > COST_MAX) begin
        acc = COST_MAX;
      end
      seen_valid = 1'b1;
      if (acc < best_run) begin
        best_run = acc;
        for (j = 0; j < JOINTS; j++) begin
          best_pose[j] = v[j];
        end
      end
    end
    if (!it.last_row) begin
      return 1'b0;
    end
    res.found     = seen_valid;
    res.best_0    = best_pose[0];
    res.best_1    = best_pose[1];
    res.best_2    = best_pose[2];
    res.best_3    = best_pose[3];
    res.best_4    = best_pose[4];
    res.best_5    = best_pose[5];
    res.best_cost = cost_t'(best_run);
    open_group();
    return 1'b1;
  endfunction

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("found=%0b best=%0d,%0d,%0d,%0d,%0d,%0d cost=%h", r.found, r.best_0,
                     r.best_1, r.best_2, r.best_3, r.best_4, r.best_5, r.best_cost);
  endfunction

  function automatic angle_t rand_angle(input angle_t center);
    angle_t x;
    case ($urandom_range(0, 7))
      0, 1, 2: x = angle_t'($urandom);
      3, 4:    x = center + angle_t'($urandom_range(0, 1023)) - 16'sd512;
      5:       x = 16'sh7fff;
      6:       x = 16'sh8000;
      default: begin
        // right at the limit or one past it, either sign
        x = angle_t'({1'b0, lim_reg}) + angle_t'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
          x = -x;
        end
      end
    endcase
    return x;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void load_directed();
    out_item_t  none;
    out_item_t  zero_hit;
    angle_vec_t mixed;
    angle_vec_t v;
    none = '0;
    none.best_cost = '1;
    zero_hit = '0;
    zero_hit.found = 1'b1;
    mixed = {16'sh5555, -16'sd1, 16'sd1, 16'sh0000, 16'sh8000, 16'sh7fff};
    // empty group right after reset, then an exact hit on the zero reference
    add_row(make_item(OP_ROW, '0, 1'b0, 1'b1), 1'b1, none);
    add_row(make_item(OP_ROW, '0, 1'b1, 1'b1), 1'b1, zero_hit);
    // reference load ignores its flags
    add_row(make_item(OP_LOAD_REF, {JOINTS{16'sh8000}}, 1'b1, 1'b1), 1'b0, none);
    add_row(make_item(OP_ROW, {JOINTS{16'sh7fff}}, 1'b1, 1'b1), 1'b0, none);
    add_row(make_item(OP_ROW, '0, 1'b1, 1'b1), 1'b0, none);
    add_row(make_item(OP_LOAD_REF, '0, 1'b0, 1'b0), 1'b0, none);
    // penalty boundary: at the limit is free, one past it is not
    add_row(make_item(OP_ROW, {JOINTS{16'sh8000}}, 1'b1, 1'b0), 1'b0, none);
    add_row(make_item(OP_ROW, {JOINTS{16'sd12868}}, 1'b1, 1'b0), 1'b0, none);
    add_row(make_item(OP_ROW, {JOINTS{16'sd12869}}, 1'b1, 1'b1), 1'b0, none);
    // equal cost: the first row stays
    v = '0;
    v[0] = 16'sd100;
    add_row(make_item(OP_ROW, v, 1'b1, 1'b0), 1'b0, none);
    v[0] = -16'sd100;
    add_row(make_item(OP_ROW, v, 1'b1, 1'b1), 1'b0, none);
    // all-invalid group
    add_row(make_item(OP_ROW, mixed, 1'b0, 1'b0), 1'b1, none);
    add_row(make_item(OP_ROW, '0, 1'b0, 1'b1), 1'b1, none);
    // invalid closing row still emits
    add_row(make_item(OP_ROW, mixed, 1'b1, 1'b0), 1'b0, none);
    add_row(make_item(OP_ROW, '0, 1'b0, 1'b1), 1'b0, none);
    add_row(make_item(OP_LOAD_REF, mixed, 1'b0, 1'b1), 1'b0, none);
    add_row(make_item(OP_ROW, mixed, 1'b1, 1'b1), 1'b0, none);
    add_row(make_item(OP_ROW, {JOINTS{16'sh7fff}}, 1'b1, 1'b1), 1'b0, none);
  endfunction

  task automatic send_item(input in_item_t it, output bit has_res, output out_item_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    has_res = score_row(it, res);
  endtask

  // results first, then room for rows that leave no result
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_ANGLE_LIMIT) begin
      lim_reg = val;
    end else begin
      wt_reg = val[WEIGHT_W-1:0];
    end
  endtask

  initial begin
    #2_000_000;
    $display("closest_joint_solution_select_test: FAIL");
    $finish;
  end

  // result side
  initial begin
    int        stall;
    out_item_t want;
    bit        bad;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: %s", fmt_result(out_ch.data));
        end
      end else begin
        want = pending_results.pop_front();
        bad = (out_ch.data.found !== want.found) || (out_ch.data.best_0 !== want.best_0) ||
              (out_ch.data.best_1 !== want.best_1) || (out_ch.data.best_2 !== want.best_2) ||
              (out_ch.data.best_3 !== want.best_3) || (out_ch.data.best_4 !== want.best_4) ||
              (out_ch.data.best_5 !== want.best_5) ||
              (out_ch.data.best_cost !== want.best_cost);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %s", fmt_result(want));
            $display("          actual   %s", fmt_result(out_ch.data));
          end
        end
      end
    end
  end

  // item side
  initial begin
    in_item_t            it;
    bit                  has_res;
    out_item_t           res;
    angle_vec_t          v;
    angle_vec_t          prev;
    logic [CFG_W-1:0]    lim_val;
    logic [CFG_W-1:0]    wt_val;
    int                  count;
    int                  kind;
    int                  rows;
    int                  p;
    int                  r;
    int                  j;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ANGLE_LIMIT;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    lim_reg = LIMIT_RESET;
    wt_reg  = WEIGHT_RESET;
    for (j = 0; j < JOINTS; j++) begin
      ref_pose[j] = '0;
    end
    open_group();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_directed();
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, has_res, res);
      if (has_res) begin
        queue_result(dir_rows[i].typed ? dir_rows[i].want : res);
      end
    end
    in_ch.valid <= 1'b0;

    for (p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin lim_val = '0;           wt_val = '1; end
        1: begin lim_val = 15'h7fff;     wt_val = '0; end
        4: begin lim_val = LIMIT_RESET;  wt_val = CFG_W'(WEIGHT_RESET); end
        default: begin
          lim_val = CFG_W'($urandom);
          wt_val  = CFG_W'($urandom);
        end
      endcase
      write_reg(REG_ANGLE_LIMIT, lim_val);
      write_reg(REG_PENALTY_WEIGHT, wt_val);
      no_gaps = (p == 1);
      count = 0;
      while (count < 100) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          // noise: any op, any flags
          for (j = 0; j < JOINTS; j++) begin
            v[j] = angle_t'($urandom);
          end
          it = make_item(op_e'($urandom_range(0, 1)), v, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
          send_item(it, has_res, res);
          if (has_res) begin
            queue_result(res);
          end
          count++;
        end else if (kind < 5) begin
          for (j = 0; j < JOINTS; j++) begin
            v[j] = rand_angle('0);
          end
          send_item(make_item(OP_LOAD_REF, v, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))), has_res, res);
          count++;
        end else begin
          rows = $urandom_range(1, 5);
          prev = '0;
          for (r = 0; r < rows; r++) begin
            for (j = 0; j < JOINTS; j++) begin
              v[j] = rand_angle(ref_pose[j]);
            end
            // a repeated row ties with the earlier one
            if (r > 0 && $urandom_range(0, 5) == 0) begin
              v = prev;
            end
            prev = v;
            it = make_item(OP_ROW, v, $urandom_range(0, 6) != 0, r == rows - 1);
            send_item(it, has_res, res);
            if (has_res) begin
              queue_result(res);
            end
            count++;
          end
        end
      end
      in_ch.valid <= 1'b0;
    end

    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("closest_joint_solution_select_test: PASS");
    end else begin
      $display("closest_joint_solution_select_test: FAIL");
    end
    $finish;
  end

endmodule
